### src/imc_pkg.sv
// Package: shared constants and item types for the interval membership counter.
package imc_pkg;

    localparam int unsigned DEPTH     = 1024;
    localparam int unsigned ADDR_W    = $clog2(DEPTH);
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned SCORE_W   = 30;
    localparam int unsigned BOUND_W   = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(1000000000);

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic [SCORE_W-1:0]        score;
        logic signed [BOUND_W-1:0] low_bound;
        logic signed [BOUND_W-1:0] high_bound;
        logic                      low_inclusive;
        logic                      high_inclusive;
    } imc_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] hit_count;
        logic             status;
    } imc_rsp_t;

endpackage

### src/interval_membership_counter.sv
// Top level: score store with append, clear and interval count queries.
//
// Usage notes. An item is taken at a rising edge where start is high and busy
// is low. Every item gives one result: done is high for exactly one cycle and
// result holds hit_count and status during that cycle only; the receiver cannot
// stall it, so sample it then. Append, clear and the unused operation code
// need no walk: the result shows in the cycle after the item is taken,
// and busy stays low, so a new item may follow at once. A query walks the
// score memory one entry per cycle through a single comparator pair; busy
// stays high while the walk runs (a query on an empty store answers at once,
// with busy low). The memory has one write and one registered read port;
// the count of valid entries bounds every read, so the memory needs no
// clearing after reset and a clear only resets the count.
module interval_membership_counter
    import imc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  imc_cmd_t command,
    output logic     busy,
    output logic     done,
    output imc_rsp_t result
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;

    // score memory and its registered read port
    logic [SCORE_W-1:0] score_mem [DEPTH];
    logic [SCORE_W-1:0] rd_data_reg;
    logic               mem_we;

    logic [CNT_W-1:0]   count_reg;     // number of valid entries
    logic [CNT_W-1:0]   issue_reg;     // next entry to read during a query
    logic               rd_valid_reg;  // rd_data_reg holds a valid entry
    logic               rd_last_reg;   // ... and it is the last one
    logic [CNT_W-1:0]   hits_reg;

    logic                      done_reg;
    imc_rsp_t                  result_reg;

    // query bounds, held for the whole walk
    logic signed [BOUND_W-1:0] lo_reg;
    logic signed [BOUND_W-1:0] hi_reg;
    logic                      lo_incl_reg;
    logic                      hi_incl_reg;

    logic                      accept;
    logic                      append_ok;
    logic signed [BOUND_W:0]   score_ext;
    logic signed [BOUND_W:0]   lo_ext;
    logic signed [BOUND_W:0]   hi_ext;
    logic                      above;
    logic                      below;
    logic [CNT_W-1:0]          hits_sum;

    assign accept    = start && (state_reg == ST_IDLE);
    assign append_ok = (count_reg < CNT_W'(DEPTH)) && (command.score <= SCORE_MAX);
    assign mem_we    = accept && (command.operation == OP_APPEND) && append_ok;

    // Compare the entry just read against both bounds, one bit wider so the
    // unsigned score and signed bounds meet on a common signed scale.
    assign score_ext = $signed({{(BOUND_W + 1 - SCORE_W){1'b0}}, rd_data_reg});
    assign lo_ext    = {lo_reg[BOUND_W-1], lo_reg};
    assign hi_ext    = {hi_reg[BOUND_W-1], hi_reg};
    assign above     = lo_incl_reg ? (score_ext >= lo_ext) : (score_ext > lo_ext);
    assign below     = hi_incl_reg ? (score_ext <= hi_ext) : (score_ext < hi_ext);
    assign hits_sum  = hits_reg + CNT_W'(above && below);

    // Memory: write the new score at the fill position, read every cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            score_mem[count_reg[ADDR_W-1:0]] <= command.score;
        end
        rd_data_reg <= score_mem[issue_reg[ADDR_W-1:0]];
    end

    // Query bounds: capture on every accepted item; only queries use them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg      <= command.low_bound;
            hi_reg      <= command.high_bound;
            lo_incl_reg <= command.low_inclusive;
            hi_incl_reg <= command.high_inclusive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            hits_reg     <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            // the strobe lasts one cycle
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (command.operation)
                            OP_APPEND:
                            begin
                                done_reg <= 1'b1;
                                if (append_ok)
                                begin
                                    count_reg            <= count_reg + CNT_W'(1);
                                    result_reg.hit_count <= count_reg + CNT_W'(1);
                                    result_reg.status    <= 1'b0;
                                end
                                else
                                begin
                                    // full store or oversized score: drop it
                                    result_reg.hit_count <= count_reg;
                                    result_reg.status    <= 1'b1;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg             <= 1'b1;
                                    result_reg.hit_count <= '0;
                                    result_reg.status    <= 1'b0;
                                end
                                else
                                begin
                                    state_reg    <= ST_SCAN;
                                    issue_reg    <= '0;
                                    rd_valid_reg <= 1'b0;
                                    rd_last_reg  <= 1'b0;
                                    hits_reg     <= '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg            <= '0;
                                done_reg             <= 1'b1;
                                result_reg.hit_count <= '0;
                                result_reg.status    <= 1'b0;
                            end
                            default:
                            begin
                                // unused code: report the count, change nothing
                                done_reg             <= 1'b1;
                                result_reg.hit_count <= count_reg;
                                result_reg.status    <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // issue side: advance through the valid entries
                    if (issue_reg < count_reg)
                    begin
                        rd_valid_reg <= 1'b1;
                        rd_last_reg  <= (issue_reg == count_reg - CNT_W'(1));
                        issue_reg    <= issue_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                        rd_last_reg  <= 1'b0;
                    end
                    // compare side: accumulate one entry per cycle
                    if (rd_valid_reg)
                    begin
                        hits_reg <= hits_sum;
                        if (rd_last_reg)
                        begin
                            done_reg             <= 1'b1;
                            result_reg.hit_count <= hits_sum;
                            result_reg.status    <= 1'b0;
                            rd_valid_reg         <= 1'b0;
                            state_reg            <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/imc_checker.sv
// Checker: port-level assertions for the interval membership counter, and its bind.
module imc_checker
    import imc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input imc_cmd_t command,
    input logic     busy,
    input logic     done,
    input imc_rsp_t result
);

    // a result never shows while a walk is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // everything but a query answers in the next cycle
    a_fast_items: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command.operation != OP_QUERY)) |=> done)
        else $error("non-query item did not answer in one cycle");

    // a clear empties the store
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command.operation == OP_CLEAR))
            |=> (result.hit_count == '0) && !result.status)
        else $error("clear did not report an empty store");

    // only an append can be dropped
    a_status_append: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> ($past(command.operation) == OP_APPEND))
        else $error("drop status on a non-append item");

    // busy is raised only by a taken query
    a_busy_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && ($past(command.operation) == OP_QUERY)))
        else $error("busy raised without a query");

endmodule

bind interval_membership_counter imc_checker u_imc_checker (.*);
